[hdl/bmp_row_pixel_unpacker_assert.svh]
// Assertion macros for the BMP row pixel unpacker.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef BMP_ROW_PIXEL_UNPACKER_ASSERT_SVH
`define BMP_ROW_PIXEL_UNPACKER_ASSERT_SVH

// Implication checked on every clock while out of reset.
`define BMPU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmpu assertion failed");

// Condition that must hold in the cycle after reset is applied.
`define BMPU_ASSERT_AFTER_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("bmpu reset assertion failed");

`endif

[hdl/bmpu_pkg.sv]
// Shared types, codes and helpers for the BMP row pixel unpacker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmpu_pkg;

    localparam int MAX_WIDTH_DEF       = 65535;
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int JOB_QUEUE_DEPTH     = 4;
    localparam int OUT_QUEUE_DEPTH     = 4;

    localparam int W_IMG_WIDTH = 16;
    localparam int W_CFG_DATA  = 16;
    localparam int W_ROW_BYTES = 18;
    localparam int W_PITCH     = 19;
    localparam int W_ROW_BITS  = 21;

    localparam logic [2:0] DEPTH_1BPP  = 3'd0;
    localparam logic [2:0] DEPTH_4BPP  = 3'd1;
    localparam logic [2:0] DEPTH_8BPP  = 3'd2;
    localparam logic [2:0] DEPTH_16BPP = 3'd3;
    localparam logic [2:0] DEPTH_24BPP = 3'd4;
    localparam logic [2:0] DEPTH_32BPP = 3'd5;

    localparam logic CFG_DEPTH_MODE  = 1'b0;
    localparam logic CFG_IMAGE_WIDTH = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        JOB_PAL_WR,
        JOB_INDEXED,
        JOB_DIRECT
    } t_job_kind;

    typedef enum logic [1:0] {
        IBPP_1,
        IBPP_4,
        IBPP_8
    } t_ibpp;

    typedef struct packed {
        t_job_kind   kind;
        t_ibpp       bpp;
        logic [3:0]  npix;
        logic        row_end;
        logic [7:0]  data;
        logic [31:0] color;
    } t_job;

    typedef struct packed {
        logic [31:0] argb;
        logic        last_byte;
        logic        last_row;
    } t_pix;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

`default_nettype wire

[hdl/bmpu_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmpu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/bmpu_fifo.sv]
// Small register FIFO, show-ahead read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmpu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

[hdl/bmpu_front.sv]
// Front end: accepts beats, tracks row position, gathers multi-byte pixels
// and issues jobs to the back end. Depends on bmpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmpu_front #(
    parameter int MAX_WIDTH = bmpu_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    input  wire logic                               i_q_full,
    input  wire logic                               i_req_type,
    input  wire logic [7:0]                         i_data_byte,
    input  wire logic [7:0]                         i_palette_index,
    input  wire logic [23:0]                        i_palette_rgb,
    input  wire logic [2:0]                         i_depth_mode,
    input  wire logic [bmpu_pkg::W_IMG_WIDTH-1:0]   i_image_width,
    output bmpu_pkg::t_job                          o_job,
    output logic                                    o_job_push
);

    import bmpu_pkg::*;

    logic [W_ROW_BYTES-1:0] r_byte_cnt, n_byte_cnt;
    logic [W_IMG_WIDTH-1:0] r_pix_cnt, n_pix_cnt;
    logic [1:0]             r_phase, n_phase;
    logic [23:0]            r_partial, n_partial;

    logic                   accept, is_data;
    logic [2:0]             mode;
    logic [W_IMG_WIDTH-1:0] eff_w;
    logic [W_ROW_BITS-1:0]  row_bits, row_bits_up;
    logic [W_PITCH-1:0]     row_bytes, pitch_sum, pitch, nb;
    logic [W_IMG_WIDTH:0]   rem;
    logic                   active, multi, emit, complete, row_wrap;
    logic [2:0]             need;
    logic [3:0]             npix;
    logic [23:0]            gathered;
    logic [31:0]            argb;
    t_job                   job;

    assign accept  = i_push && !i_q_full;
    assign is_data = !i_req_type;

    always_comb begin
        eff_w = (i_image_width > W_IMG_WIDTH'(MAX_WIDTH)) ? W_IMG_WIDTH'(MAX_WIDTH)
                                                          : i_image_width;
        unique case (i_depth_mode)
            DEPTH_1BPP:  mode = DEPTH_1BPP;
            DEPTH_4BPP:  mode = DEPTH_4BPP;
            DEPTH_16BPP: mode = DEPTH_16BPP;
            DEPTH_24BPP: mode = DEPTH_24BPP;
            DEPTH_32BPP: mode = DEPTH_32BPP;
            default:     mode = DEPTH_8BPP;
        endcase

        unique case (mode)
            DEPTH_1BPP:  row_bits = W_ROW_BITS'(eff_w);
            DEPTH_4BPP:  row_bits = W_ROW_BITS'({eff_w, 2'b00});
            DEPTH_16BPP: row_bits = W_ROW_BITS'({eff_w, 4'b0000});
            DEPTH_24BPP: row_bits = W_ROW_BITS'({eff_w, 4'b0000})
                                  + W_ROW_BITS'({eff_w, 3'b000});
            DEPTH_32BPP: row_bits = W_ROW_BITS'({eff_w, 5'b00000});
            default:     row_bits = W_ROW_BITS'({eff_w, 3'b000});
        endcase
        row_bits_up = row_bits + W_ROW_BITS'(7);
        row_bytes   = W_PITCH'(row_bits_up >> 3);
        pitch_sum   = row_bytes + W_PITCH'(3);
        pitch       = {pitch_sum[W_PITCH-1:2], 2'b00};
        nb          = W_PITCH'(r_byte_cnt) + W_PITCH'(1);
        row_wrap    = (nb >= pitch);

        rem    = (W_IMG_WIDTH + 1)'(eff_w) - (W_IMG_WIDTH + 1)'(r_pix_cnt);
        active = (r_pix_cnt < eff_w);

        gathered = r_partial;
        unique case (r_phase)
            2'd0: gathered[7:0]   = r_partial[7:0]   | i_data_byte;
            2'd1: gathered[15:8]  = r_partial[15:8]  | i_data_byte;
            2'd2: gathered[23:16] = r_partial[23:16] | i_data_byte;
            2'd3: gathered        = r_partial;
        endcase

        unique case (mode)
            DEPTH_16BPP: need = 3'd2;
            DEPTH_24BPP: need = 3'd3;
            default:     need = 3'd4;
        endcase
        complete = ((3'(r_phase) + 3'd1) >= need);

        unique case (mode)
            DEPTH_16BPP: argb = {ALPHA_OPAQUE, widen5(gathered[14:10]),
                                 widen5(gathered[9:5]), widen5(gathered[4:0])};
            DEPTH_24BPP: argb = {ALPHA_OPAQUE, gathered};
            default:     argb = {i_data_byte, gathered};
        endcase

        job       = '0;
        job.kind  = JOB_INDEXED;
        job.bpp   = IBPP_8;
        job.data  = i_data_byte;
        job.color = argb;
        multi     = 1'b0;
        emit      = 1'b1;
        npix      = 4'd1;
        unique case (mode)
            DEPTH_1BPP: begin
                job.bpp = IBPP_1;
                npix    = (rem >= (W_IMG_WIDTH + 1)'(8)) ? 4'd8 : rem[3:0];
            end
            DEPTH_4BPP: begin
                job.bpp = IBPP_4;
                npix    = (rem >= (W_IMG_WIDTH + 1)'(2)) ? 4'd2 : rem[3:0];
            end
            DEPTH_16BPP, DEPTH_24BPP, DEPTH_32BPP: begin
                job.kind = JOB_DIRECT;
                multi    = 1'b1;
                emit     = complete;
            end
            default: begin
                job.bpp = IBPP_8;
            end
        endcase
        job.npix    = npix;
        job.row_end = ((W_IMG_WIDTH + 1)'(npix) == rem);

        if (!is_data) begin
            job.kind    = JOB_PAL_WR;
            job.bpp     = IBPP_8;
            job.data    = i_palette_index;
            job.color   = {8'h00, i_palette_rgb};
            job.npix    = '0;
            job.row_end = 1'b0;
        end

        n_byte_cnt = r_byte_cnt;
        n_pix_cnt  = r_pix_cnt;
        n_phase    = r_phase;
        n_partial  = r_partial;
        if (accept && is_data) begin
            if (active && emit) begin
                n_pix_cnt = r_pix_cnt + W_IMG_WIDTH'(npix);
            end
            if (active && multi) begin
                n_phase   = complete ? 2'd0 : r_phase + 2'd1;
                n_partial = complete ? 24'd0 : gathered;
            end
            n_byte_cnt = nb[W_ROW_BYTES-1:0];
            if (row_wrap) begin
                n_byte_cnt = '0;
                n_pix_cnt  = '0;
                n_phase    = '0;
                n_partial  = '0;
            end
        end
    end

    assign o_job      = job;
    assign o_job_push = accept && (!is_data || (active && emit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_pix_cnt  <= '0;
            r_phase    <= '0;
            r_partial  <= '0;
        end else begin
            r_byte_cnt <= n_byte_cnt;
            r_pix_cnt  <= n_pix_cnt;
            r_phase    <= n_phase;
            r_partial  <= n_partial;
        end
    end

endmodule

`default_nettype wire

[hdl/bmpu_back.sv]
// Back end: runs jobs one pixel a beat while the output queue has room; palette
// lookup and writes, output queue. Depends on bmpu_pkg, bmpu_ram and bmpu_fifo.
`timescale 1ns / 1ps
`default_nettype none

module bmpu_back #(
    parameter int PALETTE_ENTRIES = bmpu_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bmpu_pkg::t_job i_job,
    input  wire logic           i_job_empty,
    output logic                o_job_pop,
    output bmpu_pkg::t_pix      o_pix,
    output logic                o_empty,
    input  wire logic           i_pop
);

    import bmpu_pkg::*;

    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int FW     = $clog2(OUT_QUEUE_DEPTH + 1);

    t_job            r_cur;
    logic            r_cur_valid;
    logic [2:0]      r_k;
    logic            r_s2_valid;
    logic            r_s2_direct;
    logic            r_s2_inrange;
    logic            r_s2_last_byte;
    logic            r_s2_last_row;
    logic [31:0]     r_s2_color;
    logic [FW-1:0]   r_inflight;

    logic            is_wr, issue, last, done, load, pix_issue, out_pop, idx_ok;
    logic [7:0]      idx;
    logic [23:0]     ram_rdata;
    logic [3:0]      k_next;
    t_pix            s2_pix;
    logic            out_full;
    logic [$bits(t_pix)-1:0] out_rdata;

    always_comb begin
        unique case (r_cur.bpp)
            IBPP_1:  idx = {7'd0, r_cur.data[3'd7 - r_k]};
            IBPP_4:  idx = r_k[0] ? {4'd0, r_cur.data[3:0]} : {4'd0, r_cur.data[7:4]};
            default: idx = r_cur.data;
        endcase
    end

    assign is_wr     = (r_cur.kind == JOB_PAL_WR);
    assign idx_ok    = ({1'b0, idx} < 9'(PALETTE_ENTRIES));
    assign issue     = r_cur_valid && (is_wr || (r_inflight < FW'(OUT_QUEUE_DEPTH)));
    assign pix_issue = issue && !is_wr;
    assign k_next    = {1'b0, r_k} + 4'd1;
    assign last      = is_wr || (k_next == r_cur.npix);
    assign done      = issue && last;
    assign load      = !i_job_empty && (!r_cur_valid || done);
    assign o_job_pop = load;
    assign out_pop   = i_pop && !o_empty;

    bmpu_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (issue && is_wr && idx_ok),
        .i_waddr (idx[PAL_AW-1:0]),
        .i_wdata (r_cur.color[23:0]),
        .i_re    (pix_issue && (r_cur.kind == JOB_INDEXED)),
        .i_raddr (idx[PAL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_k         <= '0;
            r_s2_valid  <= 1'b0;
            r_inflight  <= '0;
        end else begin
            if (load) begin
                r_cur_valid <= 1'b1;
                r_k         <= '0;
            end else if (done) begin
                r_cur_valid <= 1'b0;
            end else if (issue) begin
                r_k <= r_k + 3'd1;
            end
            r_s2_valid <= pix_issue;
            if (pix_issue && !out_pop) begin
                r_inflight <= r_inflight + 1'b1;
            end else if (out_pop && !pix_issue) begin
                r_inflight <= r_inflight - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_job;
        end
        if (pix_issue) begin
            r_s2_direct    <= (r_cur.kind == JOB_DIRECT);
            r_s2_inrange   <= idx_ok;
            r_s2_color     <= r_cur.color;
            r_s2_last_byte <= last;
            r_s2_last_row  <= last && r_cur.row_end;
        end
    end

    always_comb begin
        s2_pix.argb      = r_s2_direct ? r_s2_color
                         : {ALPHA_OPAQUE, (r_s2_inrange ? ram_rdata : 24'd0)};
        s2_pix.last_byte = r_s2_last_byte;
        s2_pix.last_row  = r_s2_last_row;
    end

    bmpu_fifo #(
        .WIDTH ($bits(t_pix)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid && !out_full),
        .i_wdata (s2_pix),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_rdata (out_rdata),
        .o_empty (o_empty)
    );

    assign o_pix = t_pix'(out_rdata);

endmodule

`default_nettype wire

[hdl/bmp_row_pixel_unpacker.sv]
// BMP row pixel unpacker: row bytes in, ARGB8888 pixels out, queue ports.
// An accepted byte passes the job queue, current job, stage 2 and output queue.
// Throughput: one byte per cycle at 8/16/24/32 bpp; at 1 and 4 bpp one pixel
// per cycle, set by the single palette read port, while no queue is full.
// Reset: synchronous active low; clears row state and queues, 8 bpp, width 1.
// Palette contents are undefined after reset and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "bmp_row_pixel_unpacker_assert.svh"

module bmp_row_pixel_unpacker #(
    parameter int MAX_WIDTH       = bmpu_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_ENTRIES = bmpu_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              i_req_type,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic [7:0]                        i_palette_index,
    input  wire logic [23:0]                       i_palette_rgb,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [31:0]                            o_pixel_argb,
    output logic                                   o_last_of_byte,
    output logic                                   o_last_of_row,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [bmpu_pkg::W_CFG_DATA-1:0]   i_cfg_data
);

    import bmpu_pkg::*;

    logic [2:0]             r_depth_mode;
    logic [W_IMG_WIDTH-1:0] r_image_width;

    t_job  front_job, q_job;
    logic  q_push, q_full, q_pop, q_empty;
    t_pix  pix;
    logic [$bits(t_job)-1:0] q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode  <= DEPTH_8BPP;
            r_image_width <= W_IMG_WIDTH'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEPTH_MODE:  r_depth_mode  <= i_cfg_data[2:0];
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[W_IMG_WIDTH-1:0];
            endcase
        end
    end

    bmpu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_q_full        (q_full),
        .i_req_type      (i_req_type),
        .i_data_byte     (i_data_byte),
        .i_palette_index (i_palette_index),
        .i_palette_rgb   (i_palette_rgb),
        .i_depth_mode    (r_depth_mode),
        .i_image_width   (r_image_width),
        .o_job           (front_job),
        .o_job_push      (q_push)
    );

    bmpu_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign q_job = t_job'(q_rdata);

    bmpu_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .o_pix       (pix),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign full           = q_full;
    assign o_pixel_argb   = pix.argb;
    assign o_last_of_byte = pix.last_byte;
    assign o_last_of_row  = pix.last_row;

    `BMPU_ASSERT_IMP(a_no_push_when_full, q_push, !q_full)
    `BMPU_ASSERT_IMP(a_pixel_job_count, q_push && (front_job.kind != JOB_PAL_WR), (front_job.npix != 4'd0) && (front_job.npix <= 4'd8))
    `BMPU_ASSERT_IMP(a_row_end_ends_byte, !empty && o_last_of_row, o_last_of_byte)
    `BMPU_ASSERT_AFTER_RST(a_reset_queues_clear, empty && !full)

endmodule

`default_nettype wire

[dv/bmp_row_pixel_unpacker_test.sv]
// Self-checking testbench for bmp_row_pixel_unpacker: row bytes and palette writes in,
// ARGB pixels checked against a cycle-free predictor held in a small scoreboard class.
// Depends on bmpu_pkg and the bmp_row_pixel_unpacker top level.
`timescale 1ns / 1ps

module bmp_row_pixel_unpacker_test;

    import bmpu_pkg::*;

    localparam logic       REQ_ROW_BYTE    = 1'b0;
    localparam logic       REQ_PAL_WRITE   = 1'b1;
    localparam logic [2:0] DEPTH_RSVD_7    = 3'd7;
    localparam int         RANDOM_ITEMS    = 430;
    localparam int         DRAIN_CYCLES    = 24;
    localparam int         HOLD_OFF_CYCLES = 160;
    localparam int         WATCHDOG_LIMIT  = 2000;

    class unpack_scoreboard;
        logic [23:0]  palette [256];
        logic [2:0]   depth_mode    = DEPTH_8BPP;
        logic [15:0]  row_width     = 16'd1;
        int unsigned  bytes_in_row  = 0;
        int unsigned  pixels_in_row = 0;
        int unsigned  byte_phase    = 0;
        logic [23:0]  gathered      = 24'd0;
        t_pix         expected_pixels [$];
        int unsigned  errors        = 0;

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        function void set_reg(logic idx, logic [15:0] data);
            if (idx == CFG_DEPTH_MODE) begin
                depth_mode = data[2:0];
            end else begin
                row_width = data;
            end
        endfunction

        function int unsigned bits_per_pixel();
            case (depth_mode)
                DEPTH_1BPP:  return 1;
                DEPTH_4BPP:  return 4;
                DEPTH_16BPP: return 16;
                DEPTH_24BPP: return 24;
                DEPTH_32BPP: return 32;
                default:     return 8;
            endcase
        endfunction

        function logic [7:0] stretch5(logic [4:0] v);
            return {v, v[4:2]};
        endfunction

        function void emit_pixel(logic [31:0] argb);
            t_pix p;
            pixels_in_row++;
            p.argb      = argb;
            p.last_byte = 1'b0;
            p.last_row  = (pixels_in_row >= row_width);
            expected_pixels.push_back(p);
        endfunction

        function void predict_pixels(logic req, logic [7:0] b, logic [7:0] idx,
                                     logic [23:0] rgb);
            int unsigned bits;
            int unsigned pitch;
            int unsigned first;
            int unsigned k;
            t_pix        tail;
            logic [31:0] argb;
            logic [15:0] raw;
            if (req == REQ_PAL_WRITE) begin
                palette[idx] = rgb;
                return;
            end
            bits  = bits_per_pixel();
            first = expected_pixels.size();
            if (pixels_in_row < row_width) begin
                if (bits == 1) begin
                    for (k = 0; k < 8 && pixels_in_row < row_width; k++)
                        emit_pixel({ALPHA_OPAQUE, palette[b[7-k]]});
                end else if (bits == 4) begin
                    emit_pixel({ALPHA_OPAQUE, palette[b[7:4]]});
                    if (pixels_in_row < row_width)
                        emit_pixel({ALPHA_OPAQUE, palette[b[3:0]]});
                end else if (bits == 8) begin
                    emit_pixel({ALPHA_OPAQUE, palette[b]});
                end else begin
                    // phase 3 carries the 32 bpp alpha and is never gathered
                    if (byte_phase < 3)
                        gathered = gathered | (24'(b) << (8 * byte_phase));
                    if (byte_phase + 1 >= bits / 8) begin
                        raw = gathered[15:0];
                        if (bits == 16)
                            argb = {ALPHA_OPAQUE, stretch5(raw[14:10]),
                                    stretch5(raw[9:5]), stretch5(raw[4:0])};
                        else if (bits == 24)
                            argb = {ALPHA_OPAQUE, gathered};
                        else
                            argb = {b, gathered};
                        emit_pixel(argb);
                        byte_phase = 0;
                        gathered   = 24'd0;
                    end else begin
                        byte_phase++;
                    end
                end
            end
            if (expected_pixels.size() > first) begin
                tail = expected_pixels.pop_back();
                tail.last_byte = 1'b1;
                expected_pixels.push_back(tail);
            end
            pitch = ((((row_width * bits) + 7) >> 3) + 3) & ~32'd3;
            bytes_in_row++;
            if (bytes_in_row >= pitch) begin
                bytes_in_row  = 0;
                pixels_in_row = 0;
                byte_phase    = 0;
                gathered      = 24'd0;
            end
        endfunction

        function void check_pixel(logic [31:0] argb, logic last_byte, logic last_row);
            t_pix want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel %h arrived, expected none", $time, argb);
                return;
            end
            want = expected_pixels.pop_front();
            if (argb !== want.argb) begin
                errors++;
                $display("%0t: pixel_argb expected %h got %h", $time, want.argb, argb);
            end
            if (last_byte !== want.last_byte) begin
                errors++;
                $display("%0t: last_of_byte expected %b got %b", $time, want.last_byte,
                         last_byte);
            end
            if (last_row !== want.last_row) begin
                errors++;
                $display("%0t: last_of_row expected %b got %b", $time, want.last_row,
                         last_row);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_req_type;
    logic [7:0]  i_data_byte;
    logic [7:0]  i_palette_index;
    logic [23:0] i_palette_rgb;
    logic        empty;
    logic        pop;
    logic [31:0] o_pixel_argb;
    logic        o_last_of_byte;
    logic        o_last_of_row;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [W_CFG_DATA-1:0] i_cfg_data;

    unpack_scoreboard sb = new();
    bit               pal_written [256];
    bit               send_quick;

    bmp_row_pixel_unpacker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_req_type      (i_req_type),
        .i_data_byte     (i_data_byte),
        .i_palette_index (i_palette_index),
        .i_palette_rgb   (i_palette_rgb),
        .empty           (empty),
        .pop             (pop),
        .o_pixel_argb    (o_pixel_argb),
        .o_last_of_byte  (o_last_of_byte),
        .o_last_of_row   (o_last_of_row),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] pick_written(input int unsigned span);
        logic [7:0] v;
        v = 8'($urandom_range(0, span - 1));
        while (!pal_written[v]) v = 8'($urandom_range(0, span - 1));
        return v;
    endfunction

    // indexed depths only ever read palette entries already loaded
    function automatic logic [7:0] next_row_byte(input logic [2:0] mode);
        logic [7:0] hi;
        logic [7:0] lo;
        case (mode)
            DEPTH_1BPP, DEPTH_16BPP, DEPTH_24BPP, DEPTH_32BPP: begin
                return 8'($urandom_range(0, 255));
            end
            DEPTH_4BPP: begin
                hi = pick_written(16);
                lo = pick_written(16);
                return {hi[3:0], lo[3:0]};
            end
            default: begin
                return pick_written(256);
            end
        endcase
    endfunction

    task automatic push_item(input logic req, input logic [7:0] b, input logic [7:0] idx,
                             input logic [23:0] rgb);
        int gap;
        gap = send_quick ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push            <= 1'b1;
        i_req_type      <= req;
        i_data_byte     <= b;
        i_palette_index <= idx;
        i_palette_rgb   <= rgb;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        sb.predict_pixels(req, b, idx, rgb);
        @(negedge i_clk);
    endtask

    task automatic push_row(input logic [7:0] b);
        push_item(REQ_ROW_BYTE, b, 8'($urandom_range(0, 255)),
                  24'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic push_palette(input logic [7:0] idx, input logic [23:0] rgb);
        pal_written[idx] = 1'b1;
        push_item(REQ_PAL_WRITE, 8'($urandom_range(0, 255)), idx, rgb);
    endtask

    task automatic configure(input logic [2:0] mode, input logic [15:0] width);
        push <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEPTH_MODE;
        i_cfg_data <= {13'd0, mode};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_IMAGE_WIDTH;
        i_cfg_data <= width;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(CFG_DEPTH_MODE, {13'd0, mode});
        sb.set_reg(CFG_IMAGE_WIDTH, width);
    endtask

    initial begin : result_sink
        int  gap;
        int  popped;
        bit  quick;
        pop    = 1'b0;
        popped = 0;
        quick  = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        forever begin
            if (popped % 25 == 0) quick = ($urandom_range(0, 2) == 0);
            gap = quick ? 0 : $urandom_range(0, 14);
            // long hold-off so the block backs up into its input
            if (popped == 30 || popped == 300) gap = HOLD_OFF_CYCLES;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty !== 1'b0) @(posedge i_clk);
            sb.check_pixel(o_pixel_argb, o_last_of_byte, o_last_of_row);
            popped++;
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0) ||
                i_cfg_we === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAIL bmp_row_pixel_unpacker");
        $finish;
    end

    initial begin : stimulus
        int unsigned random_items;
        int unsigned phase_no;
        int unsigned n;
        logic [2:0]  mode;
        logic [15:0] width;
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_req_type      = REQ_ROW_BYTE;
        i_data_byte     = 8'd0;
        i_palette_index = 8'd0;
        i_palette_rgb   = 24'd0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_DEPTH_MODE;
        i_cfg_data      = '0;
        send_quick      = 1'b0;
        random_items    = 0;
        phase_no        = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_palette(8'd0, 24'h000000);
        push_palette(8'd1, 24'hFFFFFF);
        push_palette(8'd255, 24'($urandom_range(0, 24'hFFFFFF)));
        // reset setting: 8 bpp, width 1, pitch 4; palette write inside the row
        push_row(8'hFF);
        push_palette(8'd2, 24'($urandom_range(0, 24'hFFFFFF)));
        push_row(8'h00);
        push_row(8'h55);
        push_row(8'hAA);
        configure(DEPTH_1BPP, 16'hFFFF);
        push_row(8'hA5);
        push_row(8'h5A);
        // row counters carry over into the new setting
        configure(DEPTH_4BPP, 16'd3);
        push_row(8'h10);
        push_row(8'h01);
        push_row(8'h10);
        push_row(8'h01);
        configure(DEPTH_32BPP, 16'hFFFF);
        push_row(8'h11);
        push_row(8'h22);
        push_row(8'h33);
        push_row(8'hFF);
        push_row(8'h44);
        push_row(8'h55);
        push_row(8'h66);
        // byte at the alpha phase completes a 24 bpp pixel
        configure(DEPTH_24BPP, 16'hFFFF);
        push_row(8'h80);
        configure(DEPTH_RSVD_7, 16'd1);
        push_row(next_row_byte(DEPTH_RSVD_7));
        push_row(next_row_byte(DEPTH_RSVD_7));

        while (random_items < RANDOM_ITEMS) begin
            mode = (phase_no < 8) ? 3'(phase_no) : 3'($urandom_range(0, 7));
            case ($urandom_range(0, 7))
                0:       width = 16'd1;
                1:       width = 16'hFFFF;
                2:       width = 16'($urandom_range(41, 2000));
                default: width = 16'($urandom_range(1, 40));
            endcase
            configure(mode, width);
            send_quick = ($urandom_range(0, 3) == 0);
            n = $urandom_range(12, 48);
            repeat (n) begin
                if ($urandom_range(0, 11) == 0)
                    push_palette($urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                                      : 8'($urandom_range(0, 255)),
                                 24'($urandom_range(0, 24'hFFFFFF)));
                else
                    push_row(next_row_byte(mode));
                random_items++;
            end
            phase_no++;
        end

        push <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS bmp_row_pixel_unpacker");
        else
            $display("FAIL bmp_row_pixel_unpacker");
        $finish;
    end

endmodule
